### src/qte_pkg.sv
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQ_STEPS      = 29;
    localparam int CW            = 36;
    localparam int ZW            = 35;
    localparam int RW            = 37;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    localparam logic [13:0] THR_RESET = 14'd8176;
    localparam logic [56:0] ONE_SQ    = 57'd1 << 56;

    localparam logic signed [ZW-1:0] PI_Q30   = 35'sd3373259426;
    localparam logic signed [RW-1:0] HEAD_MAX = 37'sd51472;
    localparam logic signed [RW-1:0] ATT_MAX  = 37'sd12868;
    localparam logic signed [RW-1:0] BANK_MAX = 37'sd25736;
    localparam logic signed [14:0] ATT_OUT_MAX = 15'sd12868;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } qte_lane_t;

    typedef struct packed {
        logic [1:0] pole;
        qte_lane_t  head;
        qte_lane_t  bank;
        qte_lane_t  att;
        logic [57:0] sq_v;
        logic [30:0] sq_r;
        logic [28:0] sq_q;
    } qte_item_t;

    // Elementary rotation angles atan(2^-i) in Q30 radians.
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:  a = 35'sd843314857;
            5'd1:  a = 35'sd497837829;
            5'd2:  a = 35'sd263043837;
            5'd3:  a = 35'sd133525159;
            5'd4:  a = 35'sd67021687;
            5'd5:  a = 35'sd33543516;
            5'd6:  a = 35'sd16775851;
            5'd7:  a = 35'sd8388437;
            5'd8:  a = 35'sd4194283;
            5'd9:  a = 35'sd2097149;
            5'd10: a = 35'sd1048576;
            5'd11: a = 35'sd524288;
            5'd12: a = 35'sd262144;
            5'd13: a = 35'sd131072;
            5'd14: a = 35'sd65536;
            5'd15: a = 35'sd32768;
            5'd16: a = 35'sd16384;
            5'd17: a = 35'sd8192;
            5'd18: a = 35'sd4096;
            5'd19: a = 35'sd2048;
            5'd20: a = 35'sd1024;
            5'd21: a = 35'sd512;
            5'd22: a = 35'sd256;
            5'd23: a = 35'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Moves a vector with negative x into the right half plane.
    function automatic qte_lane_t lane_prep(input qte_lane_t a);
        qte_lane_t r;
        r = a;
        r.z = '0;
        r.zero = (a.x == '0) && (a.y == '0);
        if (a.x < 0)
        begin
            r.z = (a.y >= 0) ? PI_Q30 : -PI_Q30;
            r.x = -a.x;
            r.y = -a.y;
        end
        return r;
    endfunction

    function automatic qte_lane_t lane_rot(input qte_lane_t a, input logic [4:0] idx);
        qte_lane_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        r = a;
        dx = a.y >>> idx;
        dy = a.x >>> idx;
        if (!a.zero)
        begin
            if (a.y >= 0)
            begin
                r.x = a.x + dx;
                r.y = a.y - dy;
                r.z = a.z + atan_q30(idx);
            end
            else
            begin
                r.x = a.x - dx;
                r.y = a.y + dy;
                r.z = a.z - atan_q30(idx);
            end
        end
        return r;
    endfunction

    // Q30 to Q13 with round half up, then saturation to plus or minus lim.
    function automatic logic signed [16:0] round_sat(input logic signed [RW-1:0] z,
                                                     input logic signed [RW-1:0] lim);
        logic signed [RW-1:0] r;
        r = (z + 37'sd65536) >>> 17;
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r[16:0];
    endfunction

endpackage

### src/quaternion_to_euler_angles.sv
// Quaternion to heading, attitude and bank converter. One quaternion (signed Q1.14
// components) is taken per transfer and one set of angles (radians, 13 fractional bits)
// is delivered per transfer, in order. The block sustains one transfer per clock cycle
// while the output is not stalled. The result passes through front-end registers for
// products, pole test and squaring, 29 square-root cells (one root bit each), one
// quadrant-correction stage, 16 CORDIC cells and the output register.
// Every stage holds its own valid bit, so a stalled output only backs up the pipeline as
// far as its empty slots allow. The pole threshold is written through cfg_wr_en and
// cfg_wr_data (Q0.14, reset 8176) and must only change while no transfer is in flight.
// Near the poles the block reports pole_case 1 or 2, gives heading as twice atan2(x, w)
// with sign, attitude at plus or minus pi/2 and bank of zero.
module quaternion_to_euler_angles
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] heading_angle,
    output logic signed [14:0] attitude_angle,
    output logic signed [15:0] bank_angle,
    output logic [1:0]         pole_case,
    input  logic               cfg_wr_en,
    input  logic [13:0]        cfg_wr_data
);

    localparam int NSQ = qte_pkg::SQ_STEPS;
    localparam int NCO = qte_pkg::CORDIC_STAGES;

    // Pole test threshold register.
    logic [13:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= qte_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Front end: products, pole test, asin argument and its square.
    logic               front_ready;
    logic               sq_valid [0:NSQ];
    logic               sq_ready [0:NSQ];
    qte_pkg::qte_item_t sq_item  [0:NSQ];

    qte_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .thr       (thr_reg),
        .out_valid (sq_valid[0]),
        .out_ready (sq_ready[0]),
        .out_item  (sq_item[0])
    );

    assign in_stall = !front_ready;

    // Square-root chain: the cosine term sqrt(1 - s^2) for the asin lane.
    genvar gs;
    generate
        for (gs = 0; gs < NSQ; gs++)
        begin : g_sqrt
            qte_sqrt_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (sq_valid[gs]),
                .in_ready  (sq_ready[gs]),
                .in_item   (sq_item[gs]),
                .out_valid (sq_valid[gs+1]),
                .out_ready (sq_ready[gs+1]),
                .out_item  (sq_item[gs+1])
            );
        end
    endgenerate

    // Quadrant correction: fold the root into the asin lane, move every
    // vector with negative x into the right half plane, and flag zero vectors.
    logic               co_valid [0:NCO];
    logic               co_ready [0:NCO];
    qte_pkg::qte_item_t co_item  [0:NCO];
    logic               prep_valid_reg;
    qte_pkg::qte_item_t prep_item_reg, prep_item_next;

    assign sq_ready[NSQ] = !prep_valid_reg || co_ready[0];

    always_comb
    begin
        prep_item_next       = sq_item[NSQ];
        prep_item_next.att.x = qte_pkg::CW'({1'b0, sq_item[NSQ].sq_q});
        prep_item_next.head  = qte_pkg::lane_prep(sq_item[NSQ].head);
        prep_item_next.bank  = qte_pkg::lane_prep(sq_item[NSQ].bank);
        prep_item_next.att   = qte_pkg::lane_prep(prep_item_next.att);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (sq_ready[NSQ])
        begin
            prep_valid_reg <= sq_valid[NSQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready[NSQ])
        begin
            prep_item_reg <= prep_item_next;
        end
    end

    assign co_valid[0] = prep_valid_reg;
    assign co_item[0]  = prep_item_reg;

    // CORDIC chain: each cell applies one elementary rotation to all three lanes.
    genvar gc;
    generate
        for (gc = 0; gc < NCO; gc++)
        begin : g_cordic
            qte_cordic_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (5'(gc)),
                .in_valid  (co_valid[gc]),
                .in_ready  (co_ready[gc]),
                .in_item   (co_item[gc]),
                .out_valid (co_valid[gc+1]),
                .out_ready (co_ready[gc+1]),
                .out_item  (co_item[gc+1])
            );
        end
    endgenerate

    // Output register: rounding to Q13, pole-case overrides and saturation.
    logic               ov_reg;
    logic signed [16:0] head_reg, head_next;
    logic signed [14:0] att_reg, att_next;
    logic signed [15:0] bank_reg, bank_next;
    logic [1:0]         pole_reg;
    logic signed [qte_pkg::RW-1:0] hz;
    logic signed [16:0] att_full;
    logic signed [16:0] bank_full;
    qte_pkg::qte_item_t fin;

    assign fin = co_item[NCO];
    assign co_ready[NCO] = !ov_reg || !out_stall;

    always_comb
    begin
        hz = qte_pkg::RW'(fin.head.z);
        if (fin.pole != qte_pkg::POLE_NONE)
        begin
            hz = hz * 2;
        end
        if (fin.pole == qte_pkg::POLE_SOUTH)
        begin
            hz = -hz;
        end
        head_next = qte_pkg::round_sat(hz, qte_pkg::HEAD_MAX);
        att_full  = qte_pkg::round_sat(qte_pkg::RW'(fin.att.z), qte_pkg::ATT_MAX);
        bank_full = qte_pkg::round_sat(qte_pkg::RW'(fin.bank.z), qte_pkg::BANK_MAX);
        case (fin.pole)
            qte_pkg::POLE_NORTH:
            begin
                att_next  = qte_pkg::ATT_OUT_MAX;
                bank_next = '0;
            end
            qte_pkg::POLE_SOUTH:
            begin
                att_next  = -qte_pkg::ATT_OUT_MAX;
                bank_next = '0;
            end
            default:
            begin
                att_next  = att_full[14:0];
                bank_next = bank_full[15:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (co_ready[NCO])
        begin
            ov_reg <= co_valid[NCO];
        end
    end

    always_ff @(posedge clk)
    begin
        if (co_ready[NCO])
        begin
            head_reg <= head_next;
            att_reg  <= att_next;
            bank_reg <= bank_next;
            pole_reg <= fin.pole;
        end
    end

    assign out_valid      = ov_reg;
    assign heading_angle  = head_reg;
    assign attitude_angle = att_reg;
    assign bank_angle     = bank_reg;
    assign pole_case      = pole_reg;

    // A pole result always carries zero bank.
    a_pole_bank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pole_case != qte_pkg::POLE_NONE) |-> bank_angle == '0)
        else $error("bank not zero on a pole result");

    // Attitude sits exactly on plus pi/2 at the north pole.
    a_north_att: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pole_case == qte_pkg::POLE_NORTH)
        |-> attitude_angle == qte_pkg::ATT_OUT_MAX)
        else $error("north pole attitude wrong");

    // Only the three defined pole codes leave the block.
    a_pole_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pole_case == qte_pkg::POLE_NONE) ||
                      (pole_case == qte_pkg::POLE_NORTH) ||
                      (pole_case == qte_pkg::POLE_SOUTH))
        else $error("undefined pole code");

endmodule

### src/qte_front.sv
module qte_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic [13:0]         thr,
    output logic                out_valid,
    input  logic                out_ready,
    output qte_pkg::qte_item_t  out_item
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [31:0] p_xy_reg, p_zw_reg, p_yw_reg, p_xz_reg, p_yy_reg;
    logic signed [31:0] p_zz_reg, p_xw_reg, p_yz_reg, p_xx_reg;
    logic signed [15:0] w1_reg, x1_reg;

    logic signed [32:0] t_reg, t_next;
    logic signed [33:0] hy_reg, hy_next, hx_reg, hx_next;
    logic signed [33:0] by_reg, by_next, bx_reg, bx_next;
    logic signed [15:0] w2_reg, x2_reg;

    logic [1:0]                  pole3_reg, pole3_next;
    logic signed [29:0]          s3_reg, s3_next;
    logic signed [qte_pkg::CW-1:0] hy3_reg, hy3_next, hx3_reg, hx3_next;
    logic signed [qte_pkg::CW-1:0] by3_reg, bx3_reg;

    logic [1:0]                  pole4_reg;
    logic signed [59:0]          ss_reg, ss_next;
    logic signed [29:0]          s4_reg;
    logic signed [qte_pkg::CW-1:0] hy4_reg, hx4_reg, by4_reg, bx4_reg;

    logic signed [33:0] two_t;
    logic signed [33:0] lim;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        t_next  = p_xy_reg + p_zw_reg;
        hy_next = (p_yw_reg * 2) - (p_xz_reg * 2);
        hx_next = 34'sd268435456 - (p_yy_reg * 2) - (p_zz_reg * 2);
        by_next = (p_xw_reg * 2) - (p_yz_reg * 2);
        bx_next = 34'sd268435456 - (p_xx_reg * 2) - (p_zz_reg * 2);
    end

    always_comb
    begin
        lim   = $signed({6'b0, thr, 14'b0});
        two_t = t_reg * 2;
        if (t_reg > lim)
        begin
            pole3_next = qte_pkg::POLE_NORTH;
        end
        else if (t_reg < -lim)
        begin
            pole3_next = qte_pkg::POLE_SOUTH;
        end
        else
        begin
            pole3_next = qte_pkg::POLE_NONE;
        end
        if (two_t > 34'sd268435456)
        begin
            s3_next = 30'sd268435456;
        end
        else if (two_t < -34'sd268435456)
        begin
            s3_next = -30'sd268435456;
        end
        else
        begin
            s3_next = two_t[29:0];
        end
        if (pole3_next != qte_pkg::POLE_NONE)
        begin
            hy3_next = qte_pkg::CW'(x2_reg) <<< 14;
            hx3_next = qte_pkg::CW'(w2_reg) <<< 14;
        end
        else
        begin
            hy3_next = qte_pkg::CW'(hy_reg);
            hx3_next = qte_pkg::CW'(hx_reg);
        end
    end

    assign ss_next = s3_reg * s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            p_xy_reg <= quat_x * quat_y;
            p_zw_reg <= quat_z * quat_w;
            p_yw_reg <= quat_y * quat_w;
            p_xz_reg <= quat_x * quat_z;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_xw_reg <= quat_x * quat_w;
            p_yz_reg <= quat_y * quat_z;
            p_xx_reg <= quat_x * quat_x;
            w1_reg   <= quat_w;
            x1_reg   <= quat_x;
        end
        if (rdy2)
        begin
            t_reg  <= t_next;
            hy_reg <= hy_next;
            hx_reg <= hx_next;
            by_reg <= by_next;
            bx_reg <= bx_next;
            w2_reg <= w1_reg;
            x2_reg <= x1_reg;
        end
        if (rdy3)
        begin
            pole3_reg <= pole3_next;
            s3_reg    <= s3_next;
            hy3_reg   <= hy3_next;
            hx3_reg   <= hx3_next;
            by3_reg   <= qte_pkg::CW'(by_reg);
            bx3_reg   <= qte_pkg::CW'(bx_reg);
        end
        if (rdy4)
        begin
            pole4_reg <= pole3_reg;
            ss_reg    <= ss_next;
            s4_reg    <= s3_reg;
            hy4_reg   <= hy3_reg;
            hx4_reg   <= hx3_reg;
            by4_reg   <= by3_reg;
            bx4_reg   <= bx3_reg;
        end
    end

    always_comb
    begin
        out_item           = '0;
        out_item.pole      = pole4_reg;
        out_item.head.x    = hx4_reg;
        out_item.head.y    = hy4_reg;
        out_item.bank.x    = bx4_reg;
        out_item.bank.y    = by4_reg;
        out_item.att.y     = qte_pkg::CW'(s4_reg);
        out_item.sq_v      = {1'b0, qte_pkg::ONE_SQ - ss_reg[56:0]};
    end

    assign out_valid = v4_reg;

endmodule

### src/qte_sqrt_cell.sv
module qte_sqrt_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qte_pkg::qte_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output qte_pkg::qte_item_t out_item
);

    // One result bit per cell: bring down the next bit pair, try 4q+1.
    logic               valid_reg;
    qte_pkg::qte_item_t item_reg, item_next;
    logic [32:0]        r_cat;
    logic [32:0]        trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next = in_item;
        r_cat = {in_item.sq_r, in_item.sq_v[57:56]};
        trial = {2'b0, in_item.sq_q, 2'b01};
        item_next.sq_v = {in_item.sq_v[55:0], 2'b00};
        if (r_cat >= trial)
        begin
            item_next.sq_r = 31'(r_cat - trial);
            item_next.sq_q = {in_item.sq_q[27:0], 1'b1};
        end
        else
        begin
            item_next.sq_r = r_cat[30:0];
            item_next.sq_q = {in_item.sq_q[27:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### src/qte_cordic_cell.sv
module qte_cordic_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         idx,
    input  logic               in_valid,
    output logic               in_ready,
    input  qte_pkg::qte_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output qte_pkg::qte_item_t out_item
);

    // One vectoring micro-rotation on each of the three angle lanes.
    logic               valid_reg;
    qte_pkg::qte_item_t item_reg, item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next      = in_item;
        item_next.head = qte_pkg::lane_rot(in_item.head, idx);
        item_next.bank = qte_pkg::lane_rot(in_item.bank, idx);
        item_next.att  = qte_pkg::lane_rot(in_item.att, idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### tb/sv/quaternion_to_euler_angles_test.sv
`timescale 1ns / 100ps

module quaternion_to_euler_angles_test;

    localparam longint ONE_Q28   = 64'sd268435456;
    localparam longint PI_Q30_L  = 64'sd3373259426;
    localparam int     WATCHDOG  = 20000;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct {
        logic signed [16:0] heading;
        logic signed [14:0] attitude;
        logic signed [15:0] bank;
        logic [1:0]         pole;
    } angles_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] heading_angle;
    logic signed [14:0] attitude_angle;
    logic signed [15:0] bank_angle;
    logic [1:0]         pole_case;
    logic               cfg_wr_en;
    logic [13:0]        cfg_wr_data;

    quat_t   pending_quats[$];
    angles_t expected_angles[$];
    logic [13:0] model_threshold;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      idle_cycles;
    bit      failed;
    bit      in_sent;

    quaternion_to_euler_angles uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .heading_angle(heading_angle),
        .attitude_angle(attitude_angle),
        .bank_angle(bank_angle),
        .pole_case(pole_case),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Arithmetic right shift on 64-bit values; >>> on a signed longint floors.
    function automatic longint shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sqrt_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC giving atan2(y, x) in Q30 radians.
    function automatic longint vector_angle(input longint y, input longint x);
        longint a;
        longint dx;
        longint dy;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            a = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STAGES; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                a += longint'(qte_pkg::atan_q30(i[4:0]));
            end
            else
            begin
                x -= dx;
                y += dy;
                a -= longint'(qte_pkg::atan_q30(i[4:0]));
            end
        end
        return a;
    endfunction

    // Q30 to Q13 rounding half up, then clamping to plus or minus lim.
    function automatic longint q13_clamped(input longint a, input longint lim);
        longint r;
        r = shr(a + 65536, 17);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic angles_t euler_angles(input quat_t q, input logic [13:0] thr);
        angles_t res;
        longint w;
        longint x;
        longint y;
        longint z;
        longint t;
        longint lim;
        longint a;
        longint s;
        longint c;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        t = x * y + z * w;
        lim = longint'(thr) * 16384;
        if (t > lim || t < -lim)
        begin
            a = 2 * vector_angle(x * 16384, w * 16384);
            if (t > lim)
            begin
                res.pole = qte_pkg::POLE_NORTH;
                res.attitude = 15'(qte_pkg::ATT_MAX);
            end
            else
            begin
                res.pole = qte_pkg::POLE_SOUTH;
                a = -a;
                res.attitude = -15'(qte_pkg::ATT_MAX);
            end
            res.heading = 17'(q13_clamped(a, qte_pkg::HEAD_MAX));
            res.bank = '0;
        end
        else
        begin
            s = 2 * t;
            if (s > ONE_Q28)
                s = ONE_Q28;
            if (s < -ONE_Q28)
                s = -ONE_Q28;
            c = sqrt_floor((64'd1 << 56) - longint'(s * s));
            res.pole = qte_pkg::POLE_NONE;
            res.heading = 17'(q13_clamped(vector_angle(2 * (y * w) - 2 * (x * z),
                ONE_Q28 - 2 * (y * y) - 2 * (z * z)), qte_pkg::HEAD_MAX));
            res.bank = 16'(q13_clamped(vector_angle(2 * (x * w) - 2 * (y * z),
                ONE_Q28 - 2 * (x * x) - 2 * (z * z)), qte_pkg::BANK_MAX));
            res.attitude = 15'(q13_clamped(vector_angle(s, c), qte_pkg::ATT_MAX));
        end
        return res;
    endfunction

    function automatic logic signed [15:0] any_component();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'($urandom);
        if (r == 1)
            return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Roughly unit quaternion from random direction, normalized in real arithmetic.
    function automatic quat_t random_rotation();
        quat_t q;
        real a;
        real b;
        real c;
        real d;
        real n;
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        if ($urandom_range(0, 3) == 0)
        begin
            // Bias toward the poles: with x = w and y = z, x*y+z*w becomes 2*x*y, at most one half in size.
            b = a;
            c = d;
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            n = 1.0;
        q.w = 16'($rtoi(16384.0 * a / n));
        q.x = 16'($rtoi(16384.0 * b / n));
        q.y = 16'($rtoi(16384.0 * c / n));
        q.z = 16'($rtoi(16384.0 * d / n));
        return q;
    endfunction

    task automatic add_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
        quat_t q;
        q.w = w;
        q.x = x;
        q.y = y;
        q.z = z;
        pending_quats.push_back(q);
    endtask

    // Waits for every queued quaternion to be sent and every result to be checked,
    // then lets the pipeline drain before anything changes.
    task automatic wait_drained();
        while (pending_quats.size() != 0 || expected_angles.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [13:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        model_threshold = v;
    endtask

    // Driver: presents the head of the pending queue, holding it until the
    // rising edge at which it was taken; it also drives out_stall at random.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_sent)
            begin
                if (pending_quats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    quat_w <= pending_quats[0].w;
                    quat_x <= pending_quats[0].x;
                    quat_y <= pending_quats[0].y;
                    quat_z <= pending_quats[0].z;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Input monitor: an accepted transfer gets its prediction, under the threshold
    // in force, and leaves the pending queue.
    always @(posedge clk)
    begin
        in_sent <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            quat_t q;
            q.w = quat_w;
            q.x = quat_x;
            q.y = quat_y;
            q.z = quat_z;
            expected_angles.push_back(euler_angles(q, model_threshold));
            void'(pending_quats.pop_front());
        end
    end

    // Output monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                $display("quaternion_to_euler_angles: mismatch");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    $error("result transfer with no quaternion outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    angles_t e;
                    e = expected_angles.pop_front();
                    if (heading_angle !== e.heading)
                    begin
                        $error("heading_angle expected %0d got %0d", e.heading, heading_angle);
                        failed = 1'b1;
                    end
                    if (attitude_angle !== e.attitude)
                    begin
                        $error("attitude_angle expected %0d got %0d", e.attitude,
                               attitude_angle);
                        failed = 1'b1;
                    end
                    if (bank_angle !== e.bank)
                    begin
                        $error("bank_angle expected %0d got %0d", e.bank, bank_angle);
                        failed = 1'b1;
                    end
                    if (pole_case !== e.pole)
                    begin
                        $error("pole_case expected %0d got %0d", e.pole, pole_case);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [13:0] thresholds[5];
        quat_t q;
        thresholds = '{14'd8192, 14'd0, 14'h3FFF, 14'd4096, qte_pkg::THR_RESET};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        failed = 1'b0;
        in_sent = 1'b0;
        model_threshold = qte_pkg::THR_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, the extremes, zero vectors, negative x in atan2,
        // both poles, out-of-range and non-unit inputs.
        add_quat(16384, 0, 0, 0);
        add_quat(-16384, 0, 0, 0);
        add_quat(0, 0, 0, 0);
        add_quat(0, 16384, 0, 0);
        add_quat(0, 0, 16384, 0);
        add_quat(0, 0, 0, 16384);
        add_quat(0, -16384, 0, 0);
        add_quat(8192, 8192, 8192, 8192);
        add_quat(8192, -8192, -8192, 8192);
        add_quat(-8192, 8192, -8192, 8192);
        add_quat(8192, 8192, -8192, -8192);
        add_quat(11585, 0, 0, 11585);
        add_quat(0, 11585, 11585, 0);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        add_quat(-1, 0, 0, 0);
        add_quat(0, 0, -16384, 0);
        wait_drained();

        // Random phases: each threshold setting cycles through the idling patterns.
        for (int p = 0; p < 5; p++)
        begin
            write_threshold(thresholds[p]);
            for (int k = 0; k < 4; k++)
            begin
                send_idle_pct = (k == 1 || k == 3) ? ((k == 3) ? 34 : 69) : 0;
                recv_stall_pct = (k == 2 || k == 3) ? ((k == 3) ? 34 : 69) : 0;
                for (int n = 0; n < 90; n++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        add_quat(any_component(), any_component(), any_component(),
                                 any_component());
                    end
                    else
                    begin
                        q = random_rotation();
                        pending_quats.push_back(q);
                    end
                end
                while (pending_quats.size() != 0)
                    @(posedge clk);
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
            wait_drained();
        end

        if (!failed)
        begin
            $display("quaternion_to_euler_angles: match");
        end
        else
        begin
            $display("quaternion_to_euler_angles: mismatch");
        end
        $finish;
    end
endmodule
